/* hw/rtl/sha1bsh_pkg.sv */
package sha1bsh_pkg;

  localparam int RND_W = 7;

  localparam logic [RND_W-1:0] RND_B1   = 7'd20;
  localparam logic [RND_W-1:0] RND_B2   = 7'd40;
  localparam logic [RND_W-1:0] RND_B3   = 7'd60;
  localparam logic [RND_W-1:0] RND_LAST = 7'd79;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       step;
  } sched_ctrl_t;

endpackage

/* hw/rtl/sha1bsh_round.sv */
module sha1bsh_round (
  input  sha1bsh_pkg::work_t               cur,
  input  logic [31:0]                      w,
  input  logic [sha1bsh_pkg::RND_W-1:0]    rnd,
  output sha1bsh_pkg::work_t               nxt
);
  import sha1bsh_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd < RND_B1) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K0;
    end else if (rnd < RND_B2) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K1;
    end else if (rnd < RND_B3) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K3;
    end
  end

  always_comb begin
    nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

/* hw/rtl/sha1bsh_sched.sv */
module sha1bsh_sched (
  input  logic                      clk,
  input  sha1bsh_pkg::sched_ctrl_t  ctrl,
  output logic [31:0]               w_head
);
  import sha1bsh_pkg::*;

  logic [31:0] win [16];
  logic [31:0] w_mix;
  logic [31:0] w_new;

  assign w_mix  = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_new  = {w_mix[30:0], w_mix[31]};
  assign w_head = win[0];

  // bytes shift in big-endian, oldest byte ends in the top of word 0
  always_ff @(posedge clk) begin
    if (ctrl.load_byte) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], ctrl.byte_val};
    end else if (ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

/* hw/rtl/sha1_byte_stream_hasher.sv */
// SHA-1 hasher over a byte stream. Each input transfer carries one message byte
// when s_tuser is high and ends the message when s_tlast is high; a transfer with
// s_tlast and no byte ends the message as it stands. Bytes are taken only while
// no compression or padding runs; every 64th byte also starts the compression:
// the rounds run through the single shared round unit, then the result is folded
// into the chaining words. At the end of a message the pad bytes (0x80, zeros,
// the 64-bit big-endian bit count) go into the block one per cycle through the
// same byte path, followed by one or two compressions. The digest leaves on
// m_tdata with word 0 in the lowest bits and is held until taken, while the
// next message is already accepted.
module sha1_byte_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // carries_byte
  input  logic         s_tlast,   // finish
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata    // digest_word0, digest_word1, ... digest_word4
);
  import sha1bsh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_ADD   = 4'b0100,
    S_PAD   = 4'b1000
  } state_t;

  state_t           state;
  logic [RND_W-1:0] rnd;
  work_t            work;
  work_t            work_next;
  work_t            chain;
  work_t            sum;
  logic [5:0]       fill;
  logic [63:0]      bits;
  logic             fin_pend;
  logic             pad_mark;
  logic             len_phase;
  logic             is_len;
  logic [7:0]       pad_byte;
  logic [31:0]      w_head;
  logic             s_xfer;
  logic             digest_load;
  sched_ctrl_t      sched_ctrl;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;

  assign is_len   = !pad_mark && (len_phase || fill == LEN_POS);
  assign pad_byte = pad_mark ? PAD_MARK : (is_len ? bits[63:56] : 8'h00);

  assign digest_load = (state == S_ADD) && len_phase && (!m_tvalid || m_tready);

  always_comb begin
    sched_ctrl.load_byte = 1'b0;
    sched_ctrl.byte_val  = s_tdata;
    sched_ctrl.step      = 1'b0;
    unique case (state)
      S_IDLE: begin
        sched_ctrl.load_byte = s_xfer && s_tuser;
      end
      S_PAD: begin
        sched_ctrl.load_byte = 1'b1;
        sched_ctrl.byte_val  = pad_byte;
      end
      S_ROUND: begin
        sched_ctrl.step = 1'b1;
      end
      S_ADD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sum.a = chain.a + work.a;
    sum.b = chain.b + work.b;
    sum.c = chain.c + work.c;
    sum.d = chain.d + work.d;
    sum.e = chain.e + work.e;
  end

  sha1bsh_sched u_sched (
    .clk    (clk),
    .ctrl   (sched_ctrl),
    .w_head (w_head)
  );

  sha1bsh_round u_round (
    .cur (work),
    .w   (w_head),
    .rnd (rnd),
    .nxt (work_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      chain     <= '{a: H0, b: H1, c: H2, d: H3, e: H4};
      fill      <= '0;
      bits      <= '0;
      fin_pend  <= 1'b0;
      pad_mark  <= 1'b0;
      len_phase <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (digest_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            if (s_tlast) begin
              fin_pend <= 1'b1;
              pad_mark <= 1'b1;
            end
            if (s_tuser) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            if (s_tuser && fill == BLOCK_LAST) begin
              work  <= chain;
              rnd   <= '0;
              state <= S_ROUND;
            end else if (s_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill     <= fill + 6'd1;
          pad_mark <= 1'b0;
          if (is_len) begin
            bits      <= {bits[55:0], 8'h00};
            len_phase <= 1'b1;
          end
          if (fill == BLOCK_LAST) begin
            work  <= chain;
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          work <= work_next;
          rnd  <= rnd + 7'd1;
          if (rnd == RND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (len_phase) begin
            if (digest_load) begin
              m_tdata   <= {sum.e, sum.d, sum.c, sum.b, sum.a};
              chain     <= '{a: H0, b: H1, c: H2, d: H3, e: H4};
              bits      <= '0;
              fin_pend  <= 1'b0;
              len_phase <= 1'b0;
              state     <= S_IDLE;
            end
          end else begin
            chain <= sum;
            state <= fin_pend ? S_PAD : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> rnd <= RND_LAST)
    else $error("round counter past last round");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    sched_ctrl.load_byte && fill == BLOCK_LAST |=> state == S_ROUND)
    else $error("full block did not start compression");

  a_digest_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_ADD) && $past(len_phase))
    else $error("digest raised outside final fold");

  a_idle_no_pad: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !fin_pend && !len_phase)
    else $error("input ready while padding pending");

endmodule
